@@ design/text_console_writer_defines.svh @@
// ----------------------------------------------------------------------------
// text console writer assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define TCW_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// constants, types and helpers for the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int USABLE_END = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);

    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int IDX_W      = 11;
    localparam int CURSOR_W   = 11;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_DATA,
        S_CHECK,
        S_COPY,
        S_COPY_TAIL,
        S_CLEAR_ROW,
        S_MARK,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_INIT,
        DP_LATCH,
        DP_RD_ISSUE,
        DP_RD_CAPTURE,
        DP_PUT,
        DP_COPY_START,
        DP_COPY,
        DP_COPY_TAIL,
        DP_CLEAR,
        DP_MARK,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic init_last;
        logic is_read;
        logic need_scroll;
        logic copy_last;
        logic clear_last;
        logic out_free;
    } t_dp_status;

    function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                    input logic [CHAR_W-1:0] ch);
        return {attr, ch};
    endfunction

endpackage

@@ design/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console engine with screen store, cursor and scroll
// ----------------------------------------------------------------------------
// input channel (i_valid / o_stall) takes one word: operation, char_code,
// cell_index. a put writes, backspaces or starts a new line and marks the
// cursor cell with a space; a read returns one stored cell.
// output channel (o_valid / i_stall) gives one word per input word: the
// cursor position after the operation and the read cell (0 for a put).
// config channel (i_cfg_valid / o_cfg_ready) writes the attribute byte;
// o_cfg_ready is always high.
// one word is in flight at a time. a put that scrolls runs the screen copy
// through the single ram port pair, one cell per cycle, plus one row clear.
// the block returns to idle for the next word as the result is loaded into
// the output register. after reset a clearing pass writes zero to all 2000
// cells, with o_stall high. while the receiver stalls, a finished result
// waits in the output register and the block holds its next result until
// it drains.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     i_cell_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tcw_pkg::CURSOR_W-1:0]  o_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_value
);
    import tcw_pkg::*;

    t_dp_op     cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tcw_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_operation       (i_operation),
        .i_char_code       (i_char_code),
        .i_cell_index      (i_cell_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_cursor_position (o_cursor_position),
        .o_cell_value      (o_cell_value)
    );

endmodule

@@ design/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencing state machine: clear pass, decode, read, put, scroll, emit
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_op     o_cmd
);
    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = DP_NONE;
        o_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd = DP_INIT;
                if (i_status.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd   = DP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_read) begin
                    o_cmd   = DP_RD_ISSUE;
                    n_state = S_RD_DATA;
                end else begin
                    o_cmd   = DP_PUT;
                    n_state = S_CHECK;
                end
            end
            S_RD_DATA: begin
                o_cmd   = DP_RD_CAPTURE;
                n_state = S_DONE;
            end
            S_CHECK: begin
                if (i_status.need_scroll) begin
                    o_cmd   = DP_COPY_START;
                    n_state = S_COPY;
                end else begin
                    o_cmd   = DP_MARK;
                    n_state = S_DONE;
                end
            end
            S_COPY: begin
                o_cmd = DP_COPY;
                if (i_status.copy_last) begin
                    n_state = S_COPY_TAIL;
                end
            end
            S_COPY_TAIL: begin
                o_cmd   = DP_COPY_TAIL;
                n_state = S_CLEAR_ROW;
            end
            S_CLEAR_ROW: begin
                o_cmd = DP_CLEAR;
                if (i_status.clear_last) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                o_cmd   = DP_MARK;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd   = DP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ design/tcw_dp.sv @@
// ----------------------------------------------------------------------------
// tcw_dp
// screen ram, cursor, attribute, scroll address counter and output register
// ----------------------------------------------------------------------------
module tcw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcw_pkg::t_dp_op               i_cmd,
    output tcw_pkg::t_dp_status           o_status,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    input  logic                          i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     i_cell_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tcw_pkg::CURSOR_W-1:0]  o_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_value
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0]   r_attr;
    logic                r_op;
    logic [CHAR_W-1:0]   r_char;
    logic [IDX_W-1:0]    r_idx;
    logic [ADDR_W-1:0]   r_cur;
    logic [COL_W-1:0]    r_col;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_cp_v;
    logic [CELL_W-1:0]   r_res_val;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_cur;
    logic [CELL_W-1:0]   r_out_val;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    logic [ADDR_W-1:0]   cur_dec;
    logic [ADDR_W-1:0]   copy_waddr;
    logic                idx_ok;
    logic                out_free;

    assign cur_dec    = (r_cur != '0) ? r_cur - ADDR_W'(1) : '0;
    assign copy_waddr = r_addr - ADDR_W'(COLUMNS + 1);
    assign idx_ok     = (r_idx < IDX_W'(CELL_COUNT));
    assign out_free   = !r_out_valid || !i_stall;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ram port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_raddr = r_addr;
        case (i_cmd)
            DP_INIT: begin
                ram_we = 1'b1;
            end
            DP_RD_ISSUE: begin
                ram_raddr = idx_ok ? ADDR_W'(r_idx) : '0;
            end
            DP_PUT: begin
                if (r_char == CH_BACKSPACE) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_dec;
                end else if (r_char != CH_NEWLINE) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cur;
                    ram_wdata = make_cell(r_attr, r_char);
                end
            end
            DP_COPY: begin
                ram_we    = r_cp_v;
                ram_waddr = copy_waddr;
                ram_wdata = ram_rdata;
            end
            DP_COPY_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = copy_waddr;
                ram_wdata = ram_rdata;
            end
            DP_CLEAR: begin
                ram_we = 1'b1;
            end
            DP_MARK: begin
                ram_we    = (r_cur < ADDR_W'(CELL_COUNT));
                ram_waddr = r_cur;
                ram_wdata = make_cell(r_attr, CH_SPACE);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= ATTR_RESET;
            r_cur       <= '0;
            r_col       <= '0;
            r_addr      <= '0;
            r_cp_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd == DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                DP_INIT: begin
                    r_addr <= r_addr + ADDR_W'(1);
                end
                DP_PUT: begin
                    if (r_char == CH_NEWLINE) begin
                        r_cur <= r_cur + ADDR_W'(COLUMNS) - ADDR_W'(r_col);
                        r_col <= '0;
                    end else if (r_char == CH_BACKSPACE) begin
                        r_cur <= cur_dec;
                        if (r_cur != '0) begin
                            r_col <= (r_col == '0) ? COL_W'(COLUMNS - 1)
                                                   : r_col - COL_W'(1);
                        end
                    end else begin
                        r_cur <= r_cur + ADDR_W'(1);
                        r_col <= (r_col == COL_W'(COLUMNS - 1)) ? '0
                                                                : r_col + COL_W'(1);
                    end
                end
                DP_COPY_START: begin
                    r_addr <= ADDR_W'(COLUMNS);
                    r_cp_v <= 1'b0;
                end
                DP_COPY: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    r_cp_v <= 1'b1;
                end
                DP_COPY_TAIL: begin
                    r_cur  <= r_cur - ADDR_W'(COLUMNS);
                    r_addr <= r_cur - ADDR_W'(COLUMNS);
                end
                DP_CLEAR: begin
                    r_addr <= r_addr + ADDR_W'(1);
                end
                default: begin
                    r_cp_v <= r_cp_v;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LATCH: begin
                r_op   <= i_operation;
                r_char <= i_char_code;
                r_idx  <= i_cell_index;
            end
            DP_RD_CAPTURE: begin
                r_res_val <= idx_ok ? ram_rdata : '0;
            end
            DP_MARK: begin
                r_res_val <= '0;
            end
            DP_EMIT: begin
                r_out_cur <= r_cur;
                r_out_val <= r_res_val;
            end
            default: begin
                r_res_val <= r_res_val;
            end
        endcase
    end

    assign o_status.init_last   = (r_addr == ADDR_W'(CELL_COUNT - 1));
    assign o_status.is_read     = (r_op == OP_READ);
    assign o_status.need_scroll = (r_cur >= ADDR_W'(USABLE_END));
    assign o_status.copy_last   = (r_addr == ADDR_W'(USABLE_END - 1));
    assign o_status.clear_last  = (r_addr == ADDR_W'(USABLE_END - 1));
    assign o_status.out_free    = out_free;

    assign o_valid           = r_out_valid;
    assign o_cursor_position = CURSOR_W'(r_out_cur);
    assign o_cell_value      = r_out_val;

endmodule

@@ design/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks for the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module tcw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          i_operation,
    input logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input logic [tcw_pkg::IDX_W-1:0]     i_cell_index,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [tcw_pkg::CURSOR_W-1:0]  o_cursor_position,
    input logic [tcw_pkg::CELL_W-1:0]    o_cell_value
);
    import tcw_pkg::*;

    `TCW_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid, "result dropped while stalled")
    `TCW_ASSERT_NOW(a_cursor_range, o_valid, o_cursor_position < CURSOR_W'(USABLE_END), "cursor in last row")
    `TCW_ASSERT_NEXT(a_one_in_flight, i_valid && !o_stall, o_stall, "second word taken while busy")
    `TCW_ASSERT_RST(a_reset_clear, !i_rst_n, o_stall && !o_valid, "input open during clear pass")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
